@@ rtl/core/polygon_collinear_simplify_macros.svh @@
// Assertion macros used by the checker of the block.
`ifndef POLYGON_COLLINEAR_SIMPLIFY_MACROS_SVH
`define POLYGON_COLLINEAR_SIMPLIFY_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg
// Constants, types and sequencer states of the polygon simplifier.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int BOUND_BITS = COORD_BITS + 1;
  localparam int MIN_POLY   = 3;

  // One stored vertex.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // Sequencer states, one-hot.
  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_SC_INIT = 16'h0002,
    ST_SC_W0   = 16'h0004,
    ST_SC_W1   = 16'h0008,
    ST_SC_W2   = 16'h0010,
    ST_MUL1    = 16'h0020,
    ST_MUL2    = 16'h0040,
    ST_TEST    = 16'h0080,
    ST_RM_RD   = 16'h0100,
    ST_RM_WR   = 16'h0200,
    ST_BB_RD   = 16'h0400,
    ST_BB_ACC  = 16'h0800,
    ST_EM_RD   = 16'h1000,
    ST_EM_LD   = 16'h2000,
    ST_DEG     = 16'h4000,
    ST_EM_WAIT = 16'h8000
  } state_e;

endpackage

@@ rtl/core/polygon_collinear_simplify.sv @@
// ----------------------------------------------------------------------------
// polygon_collinear_simplify
// Loads a closed polygon, removes collinear in-between vertices and emits
// the survivors with their widened bounding box.
// ----------------------------------------------------------------------------
// Points are taken one per cycle until the transfer marked last_point; the
// block then stalls its input while a small sequencer works on the 64-entry
// vertex memory through a single read port and one shared 17x17 multiplier.
// Each scan starts with a window fetch, and every vertex tested goes through
// a fetch, two multiplies and a compare. A removal shifts the tail of the
// memory down, a read and a write per entry, and restarts the scan. The
// bounding box sweep reads and accumulates each vertex; each result is read,
// loaded and held until taken. A polygon that loads fewer than three
// vertices raises out_valid_o through the degenerate state, entered from the
// transfer of its last point. The input opens again in the cycle after the
// final result transfers. No clearing pass is needed after reset.
module polygon_collinear_simplify (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [pcs_pkg::COORD_BITS-1:0]   point_x_i,
  input  logic signed [pcs_pkg::COORD_BITS-1:0]   point_y_i,
  input  logic                                    last_point_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pcs_pkg::COORD_BITS-1:0]   vertex_x_o,
  output logic signed [pcs_pkg::COORD_BITS-1:0]   vertex_y_o,
  output logic signed [pcs_pkg::BOUND_BITS-1:0]   bound_min_x_o,
  output logic signed [pcs_pkg::BOUND_BITS-1:0]   bound_min_y_o,
  output logic signed [pcs_pkg::BOUND_BITS-1:0]   bound_max_x_o,
  output logic signed [pcs_pkg::BOUND_BITS-1:0]   bound_max_y_o,
  output logic                                    degenerate_o,
  output logic                                    overflow_o,
  output logic                                    last_result_o
);

  localparam int CB = pcs_pkg::COORD_BITS;
  localparam int IB = pcs_pkg::IDX_BITS;
  localparam int NB = pcs_pkg::CNT_BITS;
  localparam int DB = pcs_pkg::DIFF_BITS;
  localparam int PB = pcs_pkg::PROD_BITS;
  localparam int BB = pcs_pkg::BOUND_BITS;
  localparam logic [NB-1:0] MaxCnt = NB'(pcs_pkg::MAX_POINTS);
  localparam logic [NB-1:0] MinCnt = NB'(pcs_pkg::MIN_POLY);
  localparam logic [NB-1:0] One    = NB'(1);

  pcs_pkg::state_e state_q, state_d;

  pcs_pkg::point_t mem_q [pcs_pkg::MAX_POINTS];
  pcs_pkg::point_t rd_q;
  logic [IB-1:0]   raddr;
  logic            we;
  logic [IB-1:0]   waddr;
  pcs_pkg::point_t wdata;

  logic [NB-1:0]   cnt_q, cnt_d;
  logic [IB-1:0]   idx_q, idx_d;
  logic            ovf_q, ovf_d;
  pcs_pkg::point_t first_q, first_d, last_q, last_d;
  pcs_pkg::point_t pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic signed [PB-1:0] prod1_q, prod1_d, prod2_q, prod2_d;
  logic signed [CB-1:0] mnx_q, mnx_d, mny_q, mny_d, mxx_q, mxx_d, mxy_q, mxy_d;

  // Output register.
  logic            ov_q, ov_d;
  pcs_pkg::point_t ovtx_q, ovtx_d;
  logic signed [BB-1:0] omnx_q, omnx_d, omny_q, omny_d, omxx_q, omxx_d, omxy_q, omxy_d;
  logic            odeg_q, odeg_d, oovf_q, oovf_d, olast_q, olast_d;

  // Load-side decisions for the point on the input.
  pcs_pkg::point_t in_pt;
  logic            in_xfer, is_new, do_store;
  logic [NB-1:0]   load_cnt;
  pcs_pkg::point_t load_last, load_first;

  // Shared multiplier and its operand selection.
  logic signed [DB-1:0] mul_a, mul_b;
  logic signed [PB-1:0] mul_p;
  logic signed [DB-1:0] dcx, dcy, dpx, dpy;
  logic                 in_box, hit;

  // Index helpers.
  logic [NB-1:0] idx_ext, idx_p1, idx_p2;
  logic [NB-1:0] cnt_m1;

  assign in_pt.x  = point_x_i;
  assign in_pt.y  = point_y_i;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign is_new   = (cnt_q == '0) || (in_pt != last_q);
  assign do_store = is_new && (cnt_q < MaxCnt);

  assign idx_ext = {1'b0, idx_q};
  assign idx_p1  = idx_ext + One;
  assign idx_p2  = idx_ext + NB'(2);
  assign cnt_m1  = cnt_q - One;

  // Differences relative to the previous vertex of the window.
  assign dcx = DB'(pc_q.x) - DB'(pa_q.x);
  assign dcy = DB'(pc_q.y) - DB'(pa_q.y);
  assign dpx = DB'(pb_q.x) - DB'(pa_q.x);
  assign dpy = DB'(pb_q.y) - DB'(pa_q.y);

  always_comb begin
    if (state_q == pcs_pkg::ST_MUL1) begin
      mul_a = dcx;
      mul_b = dpy;
    end else begin
      mul_a = dcy;
      mul_b = dpx;
    end
  end

  assign mul_p = mul_a * mul_b;

  assign in_box = ((pb_q.x >= pa_q.x && pb_q.x <= pc_q.x) ||
                   (pb_q.x <= pa_q.x && pb_q.x >= pc_q.x)) &&
                  ((pb_q.y >= pa_q.y && pb_q.y <= pc_q.y) ||
                   (pb_q.y <= pa_q.y && pb_q.y >= pc_q.y));
  assign hit = (prod1_q == prod2_q) && in_box;

  // Point count and end-of-polygon copy of the first point after a load.
  always_comb begin
    load_cnt   = cnt_q + (do_store ? One : '0);
    load_last  = do_store ? in_pt : last_q;
    load_first = (cnt_q == '0) ? in_pt : first_q;
    if (last_point_i && load_cnt > One && load_first == load_last) begin
      load_cnt = load_cnt - One;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    first_d = first_q;
    last_d  = last_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    pc_d    = pc_q;
    prod1_d = prod1_q;
    prod2_d = prod2_q;
    mnx_d   = mnx_q;
    mny_d   = mny_q;
    mxx_d   = mxx_q;
    mxy_d   = mxy_q;
    ov_d    = ov_q;
    ovtx_d  = ovtx_q;
    omnx_d  = omnx_q;
    omny_d  = omny_q;
    omxx_d  = omxx_q;
    omxy_d  = omxy_q;
    odeg_d  = odeg_q;
    oovf_d  = oovf_q;
    olast_d = olast_q;
    raddr   = '0;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = rd_q;

    unique case (state_q)
      pcs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (do_store) begin
            we     = 1'b1;
            waddr  = cnt_q[IB-1:0];
            wdata  = in_pt;
            last_d = in_pt;
            if (cnt_q == '0) begin
              first_d = in_pt;
            end
          end else if (is_new) begin
            ovf_d = 1'b1;
          end
          if (last_point_i) begin
            cnt_d   = load_cnt;
            idx_d   = '0;
            state_d = (load_cnt < MinCnt) ? pcs_pkg::ST_DEG : pcs_pkg::ST_SC_INIT;
          end else begin
            cnt_d = load_cnt;
          end
        end
      end
      // Fetch the window: previous of vertex 0, vertex 0, vertex 1.
      pcs_pkg::ST_SC_INIT: begin
        raddr   = cnt_m1[IB-1:0];
        state_d = pcs_pkg::ST_SC_W0;
      end
      pcs_pkg::ST_SC_W0: begin
        pa_d    = rd_q;
        raddr   = '0;
        state_d = pcs_pkg::ST_SC_W1;
      end
      pcs_pkg::ST_SC_W1: begin
        pb_d    = rd_q;
        raddr   = IB'(1);
        state_d = pcs_pkg::ST_SC_W2;
      end
      pcs_pkg::ST_SC_W2: begin
        pc_d    = rd_q;
        state_d = pcs_pkg::ST_MUL1;
      end
      // Cross product of the window, one product a cycle.
      pcs_pkg::ST_MUL1: begin
        prod1_d = mul_p;
        state_d = pcs_pkg::ST_MUL2;
      end
      pcs_pkg::ST_MUL2: begin
        prod2_d = mul_p;
        state_d = pcs_pkg::ST_TEST;
      end
      pcs_pkg::ST_TEST: begin
        if (hit) begin
          state_d = pcs_pkg::ST_RM_RD;
        end else if (idx_p1 == cnt_q) begin
          idx_d   = '0;
          state_d = pcs_pkg::ST_BB_RD;
        end else begin
          idx_d   = idx_p1[IB-1:0];
          pa_d    = pb_q;
          pb_d    = pc_q;
          raddr   = (idx_p2 == cnt_q) ? '0 : idx_p2[IB-1:0];
          state_d = pcs_pkg::ST_SC_W2;
        end
      end
      // Close the gap left by the removed vertex, reading and then writing each entry.
      pcs_pkg::ST_RM_RD: begin
        if (idx_p1 >= cnt_q) begin
          cnt_d   = cnt_m1;
          idx_d   = '0;
          state_d = (cnt_m1 < MinCnt) ? pcs_pkg::ST_DEG : pcs_pkg::ST_SC_INIT;
        end else begin
          raddr   = idx_p1[IB-1:0];
          state_d = pcs_pkg::ST_RM_WR;
        end
      end
      pcs_pkg::ST_RM_WR: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = rd_q;
        idx_d   = idx_p1[IB-1:0];
        state_d = pcs_pkg::ST_RM_RD;
      end
      // Bounding box sweep over the survivors.
      pcs_pkg::ST_BB_RD: begin
        raddr   = idx_q;
        state_d = pcs_pkg::ST_BB_ACC;
      end
      pcs_pkg::ST_BB_ACC: begin
        if (idx_q == '0) begin
          mnx_d = rd_q.x;
          mxx_d = rd_q.x;
          mny_d = rd_q.y;
          mxy_d = rd_q.y;
        end else begin
          if (rd_q.x < mnx_q) mnx_d = rd_q.x;
          if (rd_q.x > mxx_q) mxx_d = rd_q.x;
          if (rd_q.y < mny_q) mny_d = rd_q.y;
          if (rd_q.y > mxy_q) mxy_d = rd_q.y;
        end
        if (idx_p1 == cnt_q) begin
          idx_d   = '0;
          state_d = pcs_pkg::ST_EM_RD;
        end else begin
          idx_d   = idx_p1[IB-1:0];
          state_d = pcs_pkg::ST_BB_RD;
        end
      end
      // Present one survivor at a time.
      pcs_pkg::ST_EM_RD: begin
        raddr   = idx_q;
        state_d = pcs_pkg::ST_EM_LD;
      end
      pcs_pkg::ST_EM_LD: begin
        ov_d    = 1'b1;
        ovtx_d  = rd_q;
        omnx_d  = BB'(mnx_q) - BB'(1);
        omny_d  = BB'(mny_q) - BB'(1);
        omxx_d  = BB'(mxx_q) + BB'(1);
        omxy_d  = BB'(mxy_q) + BB'(1);
        odeg_d  = 1'b0;
        oovf_d  = ovf_q;
        olast_d = (idx_p1 == cnt_q);
        state_d = pcs_pkg::ST_EM_WAIT;
      end
      pcs_pkg::ST_DEG: begin
        ov_d    = 1'b1;
        ovtx_d  = '0;
        omnx_d  = '0;
        omny_d  = '0;
        omxx_d  = '0;
        omxy_d  = '0;
        odeg_d  = 1'b1;
        oovf_d  = ovf_q;
        olast_d = 1'b1;
        state_d = pcs_pkg::ST_EM_WAIT;
      end
      pcs_pkg::ST_EM_WAIT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = pcs_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_p1[IB-1:0];
            state_d = pcs_pkg::ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = pcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Vertex memory with registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    pc_q    <= pc_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    mnx_q   <= mnx_d;
    mny_q   <= mny_d;
    mxx_q   <= mxx_d;
    mxy_q   <= mxy_d;
    ovtx_q  <= ovtx_d;
    omnx_q  <= omnx_d;
    omny_q  <= omny_d;
    omxx_q  <= omxx_d;
    omxy_q  <= omxy_d;
    odeg_q  <= odeg_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
  end

  assign in_stall_o    = (state_q != pcs_pkg::ST_IDLE);
  assign out_valid_o   = ov_q;
  assign vertex_x_o    = ovtx_q.x;
  assign vertex_y_o    = ovtx_q.y;
  assign bound_min_x_o = omnx_q;
  assign bound_min_y_o = omny_q;
  assign bound_max_x_o = omxx_q;
  assign bound_max_y_o = omxy_q;
  assign degenerate_o  = odeg_q;
  assign overflow_o    = oovf_q;
  assign last_result_o = olast_q;

endmodule

@@ rtl/core/pcs_checker.sv @@
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the polygon simplifier, bound to its top level.
// ----------------------------------------------------------------------------
`include "polygon_collinear_simplify_macros.svh"

module pcs_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  last_point_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [pcs_pkg::COORD_BITS-1:0] vertex_x_o,
  input logic signed [pcs_pkg::COORD_BITS-1:0] vertex_y_o,
  input logic                                  degenerate_o,
  input logic                                  last_result_o
);

  // Input is held off while any result is on offer.
  `PCS_ASSERT_IMP(a_busy_out, out_valid_o, in_stall_o)

  // The final point of a polygon starts the work, so input stalls next.
  `PCS_ASSERT_NXT(a_last_stall, in_valid_i && !in_stall_o && last_point_i, in_stall_o)

  // A degenerate polygon has a single, zeroed result.
  `PCS_ASSERT_IMP(a_deg_last, out_valid_o && degenerate_o,
                  last_result_o && vertex_x_o == '0 && vertex_y_o == '0)

  // A stalled result holds.
  `PCS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(vertex_x_o) && $stable(last_result_o))

endmodule

bind polygon_collinear_simplify pcs_checker u_pcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .last_point_i (last_point_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .vertex_x_o   (vertex_x_o),
  .vertex_y_o   (vertex_y_o),
  .degenerate_o (degenerate_o),
  .last_result_o(last_result_o)
);
